>>> design/rwcl_pkg.sv
package rwcl_pkg;

    // Beacon table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;

    // Field widths
    localparam int MAC_W     = 32;
    localparam int COORD_W   = 16;
    localparam int RSSI_W    = 8;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    // Arithmetic widths
    localparam int SVAL_W = 9;
    localparam int W_W    = 21;
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 48;
    localparam int WSUM_W = 32;
    localparam int MCNT_W = 12;
    localparam int DVSR_W = 34;

    // Weight constants: w = trunc((rssi + 50)^3 / 10)
    localparam int RSSI_OFFSET = 50;
    localparam int RECIP_10    = 13421773;
    localparam int RECIP_SHIFT = 27;

    localparam int SEEN_MAX = 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MEAS = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_NEAREST,
        ST_CENTROID,
        ST_ZERO_DIV
    } status_t;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tbl_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CUBE,
        S_RECIP,
        S_WEIGHT,
        S_CMP,
        S_MX,
        S_MY,
        S_END,
        S_DIVX,
        S_DIVY,
        S_OUT
    } state_t;

endpackage

>>> design/rwcl_table.sv
module rwcl_table
    import rwcl_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [TABLE_AW-1:0] wr_addr,
    input  tbl_entry_t          wr_data,
    input  logic                rd_en,
    input  logic [TABLE_AW-1:0] rd_addr,
    output tbl_entry_t          rd_data
);

    tbl_entry_t beacon_mem [TABLE_DEPTH];
    tbl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            beacon_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= beacon_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rwcl_mul.sv
module rwcl_mul
    import rwcl_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> design/rwcl_div.sv
module rwcl_div
    import rwcl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ACC_W-1:0]   dividend,
    input  logic signed [DVSR_W-1:0]  divisor,
    output logic                      done,
    output logic signed [COORD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(ACC_W);
    localparam logic [ACC_W-1:0] POS_LIMIT = ACC_W'(2**(COORD_W-1) - 1);
    localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(2**(COORD_W-1));

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg;
    logic [ACC_W-1:0]  quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;

    logic [DVSR_W:0] trial;
    logic [DVSR_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[ACC_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Restoring division on magnitudes, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[ACC_W-1] ^ divisor[DVSR_W-1];
            quo_reg  <= dividend[ACC_W-1] ? -dividend : dividend;
            dvsr_reg <= divisor[DVSR_W-1] ? -divisor : divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (quo_reg > NEG_LIMIT) ? -NEG_LIMIT[COORD_W-1:0]
                                             : -quo_reg[COORD_W-1:0];
        end
        else
        begin
            quotient = (quo_reg > POS_LIMIT) ? POS_LIMIT[COORD_W-1:0]
                                             : quo_reg[COORD_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

>>> design/rssi_weighted_centroid_locator.sv
// RSSI weighted centroid locator.
// Input stream (s_*): tuser selects a load item (0) that writes one beacon slot
// or a measurement item (1); tlast marks the last measurement of a list.
// Output stream (m_*): one item per list, on its last measurement: position in
// tdata, status in tuser. Configuration (cfg_*): number of table slots in use.
// Steps: a measurement first builds its weight in the shared multiplier (square,
// cube, then the reciprocal multiply for the division by ten), then the table
// scan reads one slot a cycle while no slot matches; each match holds the scan
// while the multiplier forms x*w and y*w. A last item that ends in a centroid
// runs two 48-step serial divisions, for x and then y, with one quotient bit a
// cycle; every last item then loads the output register. A load item writes
// its table slot while the block is idle.
// s_tready is high only while the block is idle; one item is in work at a time.
// The result sits in an output register; while the receiver stalls, the block
// still takes new items and halts only when a further result has to be sent.
// Reset clears the register, the accumulators and the output valid; table
// contents stay undefined until loaded.
module rssi_weighted_centroid_locator
    import rwcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index[5:0], mac[37:6], coord_x[53:38], coord_y[69:54], rssi[77:70]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_x[15:0], pos_y[31:16]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          te_reg;
    logic [MAC_W-1:0]          mac_reg, mac_next;
    logic [RSSI_W-1:0]         rssi_reg, rssi_next;
    logic                      last_reg, last_next;
    logic                      cube_neg_reg, cube_neg_next;
    logic signed [W_W-1:0]     w_reg, w_next;
    logic [CNT_W-1:0]          scan_idx_reg, scan_idx_next;
    logic signed [ACC_W-1:0]   sum_x_reg, sum_x_next;
    logic signed [ACC_W-1:0]   sum_y_reg, sum_y_next;
    logic signed [WSUM_W-1:0]  wsum_reg, wsum_next;
    logic [MCNT_W-1:0]         mcnt_reg, mcnt_next;
    logic [1:0]                seen_reg, seen_next;
    logic [COORD_W-1:0]        first_x_reg, first_x_next;
    logic [COORD_W-1:0]        first_y_reg, first_y_next;
    logic                      first_found_reg, first_found_next;
    logic [COORD_W-1:0]        res_x_reg, res_x_next;
    logic [COORD_W-1:0]        res_y_reg, res_y_next;
    status_t                   res_status_reg, res_status_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;
    status_t                   m_tuser_reg, m_tuser_next;

    logic                      tbl_wr_en;
    tbl_entry_t                tbl_wr_data;
    logic                      tbl_rd_en;
    logic [TABLE_AW-1:0]       tbl_rd_addr;
    tbl_entry_t                tbl_rd_data;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      div_start;
    logic signed [ACC_W-1:0]   div_dividend;
    logic signed [DVSR_W-1:0]  divisor;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_q;

    logic [CNT_W-1:0]          n_active;
    logic [CNT_W-1:0]          scan_next;
    logic                      last_entry;
    logic                      mac_hit;
    logic [1:0]                seen_inc;
    logic                      short_hit;
    logic signed [SVAL_W-1:0]  s_val;
    logic [MUL_W-1:0]          cube_mag;
    logic [W_W-1:0]            w_mag;
    logic                      out_free;

    assign n_active   = (te_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : te_reg;
    assign scan_next  = scan_idx_reg + 1'b1;
    assign last_entry = (scan_next >= n_active);
    assign mac_hit    = (tbl_rd_data.mac == mac_reg);
    assign seen_inc   = (seen_reg == 2'(SEEN_MAX)) ? seen_reg : seen_reg + 2'd1;
    assign short_hit  = (seen_inc < 2'(SEEN_MAX)) && first_found_reg;
    assign s_val      = SVAL_W'(signed'(rssi_reg)) + SVAL_W'(RSSI_OFFSET);
    assign cube_mag   = prod[MUL_W-1] ? -prod[MUL_W-1:0] : prod[MUL_W-1:0];
    assign w_mag      = {1'b0, prod[RECIP_SHIFT+W_W-2:RECIP_SHIFT]};
    assign divisor    = DVSR_W'(mcnt_reg) + DVSR_W'(wsum_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign tbl_wr_data.mac = s_tdata[37:6];
    assign tbl_wr_data.x   = s_tdata[53:38];
    assign tbl_wr_data.y   = s_tdata[69:54];

    rwcl_table u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (s_tdata[TABLE_AW-1:0]),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    rwcl_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rwcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tuser == FUNC_MEAS)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:     state_next = S_CUBE;
            S_CUBE:   state_next = S_RECIP;
            S_RECIP:  state_next = S_WEIGHT;
            S_WEIGHT: state_next = (n_active == '0) ? S_END : S_CMP;
            S_CMP:
            begin
                if (mac_hit)
                begin
                    state_next = S_MX;
                end
                else if (last_entry)
                begin
                    state_next = S_END;
                end
            end
            S_MX:     state_next = S_MY;
            S_MY:     state_next = last_entry ? S_END : S_CMP;
            S_END:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (short_hit || mcnt_reg == '0 || divisor == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        s_tready         = 1'b0;
        tbl_wr_en        = 1'b0;
        tbl_rd_en        = 1'b0;
        tbl_rd_addr      = scan_next[TABLE_AW-1:0];
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;
        div_dividend     = sum_x_reg;
        mac_next         = mac_reg;
        rssi_next        = rssi_reg;
        last_next        = last_reg;
        cube_neg_next    = cube_neg_reg;
        w_next           = w_reg;
        scan_idx_next    = scan_idx_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        wsum_next        = wsum_reg;
        mcnt_next        = mcnt_reg;
        seen_next        = seen_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        first_found_next = first_found_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_LOAD)
                    begin
                        tbl_wr_en = 1'b1;
                    end
                    else
                    begin
                        mac_next  = s_tdata[37:6];
                        rssi_next = s_tdata[77:70];
                        last_next = s_tlast;
                    end
                end
            end
            S_SQ:
            begin
                mul_a = MUL_W'(s_val);
                mul_b = MUL_W'(s_val);
            end
            S_CUBE:
            begin
                mul_a = signed'(prod[MUL_W-1:0]);
                mul_b = MUL_W'(s_val);
            end
            S_RECIP:
            begin
                // |cube| / 10 by reciprocal multiply, exact below 2^26
                cube_neg_next = prod[MUL_W-1];
                mul_a         = signed'(cube_mag);
                mul_b         = MUL_W'(RECIP_10);
            end
            S_WEIGHT:
            begin
                w_next        = cube_neg_reg ? -signed'(w_mag) : signed'(w_mag);
                scan_idx_next = '0;
                tbl_rd_en     = (n_active != '0);
                tbl_rd_addr   = '0;
            end
            S_CMP:
            begin
                if (mac_hit)
                begin
                    if (seen_reg == '0 && !first_found_reg)
                    begin
                        first_found_next = 1'b1;
                        first_x_next     = tbl_rd_data.x;
                        first_y_next     = tbl_rd_data.y;
                    end
                    mul_a = MUL_W'(signed'(tbl_rd_data.x));
                    mul_b = MUL_W'(w_reg);
                end
                else if (!last_entry)
                begin
                    scan_idx_next = scan_next;
                    tbl_rd_en     = 1'b1;
                end
            end
            S_MX:
            begin
                sum_x_next = sum_x_reg + prod[ACC_W-1:0];
                mul_a      = MUL_W'(signed'(tbl_rd_data.y));
                mul_b      = MUL_W'(w_reg);
            end
            S_MY:
            begin
                sum_y_next = sum_y_reg + prod[ACC_W-1:0];
                wsum_next  = wsum_reg + WSUM_W'(w_reg);
                mcnt_next  = mcnt_reg + 1'b1;
                if (!last_entry)
                begin
                    scan_idx_next = scan_next;
                    tbl_rd_en     = 1'b1;
                end
            end
            S_END:
            begin
                seen_next = seen_inc;
                if (last_reg)
                begin
                    res_x_next = '0;
                    res_y_next = '0;
                    if (short_hit)
                    begin
                        res_x_next      = first_x_reg;
                        res_y_next      = first_y_reg;
                        res_status_next = ST_NEAREST;
                    end
                    else if (mcnt_reg == '0)
                    begin
                        res_status_next = ST_NONE;
                    end
                    else if (divisor == '0)
                    begin
                        res_status_next = ST_ZERO_DIV;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = sum_x_reg;
                    end
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    res_x_next   = div_q;
                    div_start    = 1'b1;
                    div_dividend = sum_y_reg;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    res_y_next      = div_q;
                    res_status_next = ST_CENTROID;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = {res_y_reg, res_x_reg};
                    m_tuser_next     = res_status_reg;
                    // Drop the list state for the next run
                    sum_x_next       = '0;
                    sum_y_next       = '0;
                    wsum_next        = '0;
                    mcnt_next        = '0;
                    seen_next        = '0;
                    first_x_next     = '0;
                    first_y_next     = '0;
                    first_found_next = 1'b0;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            te_reg          <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            wsum_reg        <= '0;
            mcnt_reg        <= '0;
            seen_reg        <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            first_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_valid)
            begin
                te_reg <= cfg_data;
            end
            sum_x_reg       <= sum_x_next;
            sum_y_reg       <= sum_y_next;
            wsum_reg        <= wsum_next;
            mcnt_reg        <= mcnt_next;
            seen_reg        <= seen_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            first_found_reg <= first_found_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg        <= mac_next;
        rssi_reg       <= rssi_next;
        last_reg       <= last_next;
        cube_neg_reg   <= cube_neg_next;
        w_reg          <= w_next;
        scan_idx_reg   <= scan_idx_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

>>> design/rwcl_checker.sv
module rwcl_checker
    import rwcl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No match and zero divisor report the origin
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_NONE || m_tuser == ST_ZERO_DIV) |-> m_tdata == '0)
        else $error("nonzero position with no-match or zero-divisor status");

    // The block is not ready again in the cycle after it takes a measurement item
    a_meas_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_MEAS |=> !s_tready)
        else $error("input ready right after a measurement item");

endmodule

bind rssi_weighted_centroid_locator rwcl_checker u_rwcl_checker (.*);
